// ===== src/orld_pkg.sv =====
// ----------------------------------------------------------------------------
// orld_pkg: shared definitions for the opcode RLE/LZ byte decompressor
// Opcode codes, phase and status codes, generator kinds, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package orld_pkg;

  localparam int WINDOW_DEPTH = 4096;
  localparam int HIST_AW      = $clog2(WINDOW_DEPTH);
  localparam int RESULT_BYTES = 16;
  localparam int PACK_CW      = $clog2(RESULT_BYTES + 1);
  localparam int PACK_IW      = $clog2(RESULT_BYTES);
  localparam int GEN_W        = 10;   // up to 771 bytes per opcode
  localparam int CFG_AW       = 3;

  localparam logic [23:0] COUNT_MAX = 24'hFFFFFF;

  // configuration register addresses
  localparam logic [CFG_AW-1:0] REG_OUTPUT_LIMIT = 3'd0;

  // opcodes
  localparam logic [7:0] OP_LIT_MAX  = 8'hEF;
  localparam logic [7:0] OP_FILL_NIB = 8'hF0;
  localparam logic [7:0] OP_FILL     = 8'hF1;
  localparam logic [7:0] OP_NIB_PAIR = 8'hF2;
  localparam logic [7:0] OP_PAT2     = 8'hF3;
  localparam logic [7:0] OP_PAT3     = 8'hF4;
  localparam logic [7:0] OP_STR1     = 8'hF5;
  localparam logic [7:0] OP_STR2     = 8'hF6;
  localparam logic [7:0] OP_STR3     = 8'hF7;
  localparam logic [7:0] OP_INC      = 8'hF8;
  localparam logic [7:0] OP_DEC      = 8'hF9;
  localparam logic [7:0] OP_STEP     = 8'hFA;
  localparam logic [7:0] OP_ACC16    = 8'hFB;
  localparam logic [7:0] OP_REF12    = 8'hFC;
  localparam logic [7:0] OP_REF8     = 8'hFD;
  localparam logic [7:0] OP_REFNIB   = 8'hFE;
  localparam logic [7:0] OP_END      = 8'hFF;

  // parameter phases
  localparam logic [2:0] PH_OPCODE  = 3'd0;
  localparam logic [2:0] PH_LITERAL = 3'd5;
  localparam logic [2:0] PH_STREAM  = 3'd6;

  // stop status codes
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_END   = 2'd1;
  localparam logic [1:0] ST_SRC   = 2'd2;
  localparam logic [1:0] ST_LIMIT = 2'd3;

  typedef enum logic [1:0] {
    GK_SEQ   = 2'd0,
    GK_ARITH = 2'd1,
    GK_ACC   = 2'd2,
    GK_COPY  = 2'd3
  } gen_kind_t;

  typedef struct packed {
    logic capture;   // latch request payload
    logic decode;    // apply opcode/parameter handling
    logic settle;    // update output count and stop status
    logic rd_issue;  // read history for a back-reference
    logic emit;      // produce one output byte
    logic flush;     // move packed bytes to output register
  } cmd_t;

  typedef struct packed {
    logic gen_done;
    logic pack_full;
    logic is_copy;
    logic out_free;
  } sts_t;

  // parameter bytes needed by each multi-byte opcode
  function automatic logic [2:0] param_count(input logic [7:0] op);
    logic [2:0] n;
    case (op)
      OP_FILL_NIB, OP_REFNIB:        n = 3'd1;
      OP_PAT2, OP_STR2, OP_STEP:     n = 3'd3;
      OP_PAT3, OP_STR3, OP_ACC16:    n = 3'd4;
      default:                       n = 3'd2;
    endcase
    return n;
  endfunction

endpackage

// ===== src/orld_if.sv =====
// ----------------------------------------------------------------------------
// orld_if: request and result channels
// Valid/ready channels carrying one compressed byte in, one result out.
// ----------------------------------------------------------------------------
interface orld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;
  logic       last_of_call;
  logic       first_of_call;

  modport source (output valid, source_byte, last_of_call, first_of_call, input ready);
  modport sink   (input valid, source_byte, last_of_call, first_of_call, output ready);
endinterface

interface orld_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_low;
  logic [63:0] data_high;
  logic [4:0]  byte_count;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, data_low, data_high, byte_count, status, last, input ready);
  modport sink   (input valid, data_low, data_high, byte_count, status, last, output ready);
endinterface

// ===== src/orld_ctrl.sv =====
// ----------------------------------------------------------------------------
// orld_ctrl: decompressor sequencer
// Steps each request through decode, status update, byte generation and
// result flushing.
// ----------------------------------------------------------------------------
module orld_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  orld_pkg::sts_t sts,
  output orld_pkg::cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SETTLE = 6'b000100,
    S_GEN    = 6'b001000,
    S_COPYW  = 6'b010000,
    S_FLUSH  = 6'b100000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        state_next = S_SETTLE;
      end
      S_SETTLE: begin
        cmd.settle = 1'b1;
        state_next = S_GEN;
      end
      S_GEN: begin
        if (sts.gen_done || sts.pack_full) begin
          state_next = S_FLUSH;
        end else if (sts.is_copy) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_COPYW;
        end else begin
          cmd.emit = 1'b1;
        end
      end
      S_COPYW: begin
        cmd.emit   = 1'b1;
        state_next = S_GEN;
      end
      S_FLUSH: begin
        if (sts.out_free) begin
          cmd.flush  = 1'b1;
          state_next = sts.gen_done ? S_IDLE : S_GEN;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/orld_dpath.sv =====
// ----------------------------------------------------------------------------
// orld_dpath: decompressor datapath
// Parameter collection, run generators, history memory, result packing and
// the result register.
// ----------------------------------------------------------------------------
module orld_dpath (
  input  logic           clk,
  input  logic           rst,
  input  orld_pkg::cmd_t cmd,
  output orld_pkg::sts_t sts,
  input  logic [7:0]     in_byte_d,
  input  logic           in_last_d,
  input  logic           in_first_d,
  input  logic [23:0]    limit,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [63:0]    out_data_low,
  output logic [63:0]    out_data_high,
  output logic [4:0]     out_byte_count,
  output logic [1:0]     out_status,
  output logic           out_last
);

  localparam int AW = orld_pkg::HIST_AW;
  localparam int GW = orld_pkg::GEN_W;
  localparam int RB = orld_pkg::RESULT_BYTES;

  // request latch
  logic [7:0] in_byte;
  logic       in_last, in_first;

  // decoder state
  logic [1:0]  stopped, stopped_next;
  logic        src_end, src_end_next;
  logic [23:0] count, count_next;
  logic [7:0]  op, op_next;
  logic [7:0]  prm [4];
  logic [7:0]  prm_w [4];
  logic [2:0]  phase, phase_next;
  logic [8:0]  rem, rem_next;
  logic        fin_pend, fin;

  // generator state
  orld_pkg::gen_kind_t kind, kind_next;
  logic [7:0]    seq [4];
  logic [7:0]    seq_n [4];
  logic [1:0]    seq_last, seq_last_next;
  logic [1:0]    seq_pos;
  logic [15:0]   val, val_next;
  logic [15:0]   stepv, stepv_next;
  logic [AW-1:0] ref_dist, ref_dist_next;
  logic [GW-1:0] gen_left, gl;

  // history memory
  logic [7:0]    hist [orld_pkg::WINDOW_DEPTH];
  logic [AW-1:0] hist_wr;
  logic [7:0]    rd_data;

  // packing
  logic [7:0]         pack [RB];
  logic [orld_pkg::PACK_CW-1:0] pack_cnt;

  logic [7:0] gen_byte;
  logic [1:0] st0;
  logic [23:0] cnt0;
  logic        se0;
  logic [8:0]  rem_dec;
  logic [24:0] cnt_sum;
  logic [23:0] cnt_new;
  logic [GW-1:0] p0x;

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_byte  <= in_byte_d;
      in_last  <= in_last_d;
      in_first <= in_first_d;
    end
  end

  // opcode and parameter handling for one request byte
  always_comb begin
    st0  = in_first ? orld_pkg::ST_RUN : stopped;
    cnt0 = in_first ? 24'd0 : count;
    se0  = in_first ? 1'b0 : src_end;
    stopped_next  = st0;
    count_next    = cnt0;
    src_end_next  = se0;
    op_next       = op;
    phase_next    = phase;
    rem_next      = rem;
    fin           = 1'b0;
    gl            = '0;
    kind_next     = orld_pkg::GK_SEQ;
    seq_last_next = 2'd0;
    val_next      = val;
    stepv_next    = stepv;
    ref_dist_next = ref_dist;
    rem_dec       = (rem != 9'd0) ? rem - 9'd1 : 9'd0;
    p0x           = '0;
    for (int i = 0; i < 4; i++) begin
      prm_w[i] = prm[i];
      seq_n[i] = seq[i];
    end
    if (st0 == orld_pkg::ST_RUN) begin
      if (phase == orld_pkg::PH_OPCODE && cnt0 >= limit) begin
        stopped_next = orld_pkg::ST_LIMIT;
      end else begin
        src_end_next = se0 | in_last;
        case (phase)
          orld_pkg::PH_OPCODE: begin
            op_next = in_byte;
            if (in_byte <= orld_pkg::OP_LIT_MAX) begin
              rem_next   = {1'b0, in_byte} + 9'd1;
              phase_next = orld_pkg::PH_LITERAL;
            end else if (in_byte == orld_pkg::OP_END) begin
              stopped_next = orld_pkg::ST_END;
            end else begin
              phase_next = 3'd1;
            end
          end
          3'd1, 3'd2, 3'd3, 3'd4: begin
            prm_w[2'(phase - 3'd1)] = in_byte;
            if (phase >= orld_pkg::param_count(op)) begin
              fin        = 1'b1;
              phase_next = orld_pkg::PH_OPCODE;
              p0x        = {{(GW-8){1'b0}}, prm_w[0]};
              case (op)
                orld_pkg::OP_FILL_NIB: begin
                  seq_n[0] = {4'h0, prm_w[0][7:4]};
                  gl       = {{(GW-4){1'b0}}, prm_w[0][3:0]} + GW'(3);
                end
                orld_pkg::OP_FILL: begin
                  seq_n[0] = prm_w[1];
                  gl       = p0x + GW'(4);
                end
                orld_pkg::OP_NIB_PAIR: begin
                  seq_n[0]      = {4'h0, prm_w[1][3:0]};
                  seq_n[1]      = {4'h0, prm_w[1][7:4]};
                  seq_last_next = 2'd1;
                  gl            = (p0x + GW'(2)) << 1;
                end
                orld_pkg::OP_PAT2: begin
                  seq_n[0]      = prm_w[1];
                  seq_n[1]      = prm_w[2];
                  seq_last_next = 2'd1;
                  gl            = (p0x + GW'(2)) << 1;
                end
                orld_pkg::OP_PAT3: begin
                  seq_n[0]      = prm_w[1];
                  seq_n[1]      = prm_w[2];
                  seq_n[2]      = prm_w[3];
                  seq_last_next = 2'd2;
                  gl            = ((p0x + GW'(2)) << 1) + (p0x + GW'(2));
                end
                orld_pkg::OP_STR1, orld_pkg::OP_STR2, orld_pkg::OP_STR3: begin
                  // interleaved runs continue on following stream bytes
                  fin        = 1'b0;
                  phase_next = orld_pkg::PH_STREAM;
                  rem_next   = {1'b0, prm_w[0]} +
                               ((op == orld_pkg::OP_STR1) ? 9'd4 :
                                (op == orld_pkg::OP_STR2) ? 9'd3 : 9'd2);
                end
                orld_pkg::OP_INC, orld_pkg::OP_DEC, orld_pkg::OP_STEP: begin
                  kind_next  = orld_pkg::GK_ARITH;
                  val_next   = {8'h00, prm_w[1]};
                  stepv_next = (op == orld_pkg::OP_INC) ? 16'h0001 :
                               (op == orld_pkg::OP_DEC) ? 16'h00FF : {8'h00, prm_w[2]};
                  gl         = p0x + ((op == orld_pkg::OP_STEP) ? GW'(5) : GW'(4));
                end
                orld_pkg::OP_ACC16: begin
                  kind_next  = orld_pkg::GK_ACC;
                  val_next   = {prm_w[2], prm_w[1]};
                  stepv_next = {{8{prm_w[3][7]}}, prm_w[3]};
                  gl         = (p0x + GW'(3)) << 1;
                end
                orld_pkg::OP_REF12: begin
                  kind_next     = orld_pkg::GK_COPY;
                  ref_dist_next = AW'({prm_w[1][3:0], prm_w[0]}) + AW'(1);
                  gl            = {{(GW-4){1'b0}}, prm_w[1][7:4]} + GW'(4);
                end
                orld_pkg::OP_REF8: begin
                  kind_next     = orld_pkg::GK_COPY;
                  ref_dist_next = AW'(prm_w[0]) + AW'(1);
                  gl            = {{(GW-8){1'b0}}, prm_w[1]} + GW'(20);
                end
                orld_pkg::OP_REFNIB: begin
                  kind_next     = orld_pkg::GK_COPY;
                  ref_dist_next = AW'({prm_w[0][7:4], 3'b000}) + AW'(8);
                  gl            = {{(GW-4){1'b0}}, prm_w[0][3:0]} + GW'(3);
                end
                default: begin
                  gl = '0;
                end
              endcase
            end else begin
              phase_next = phase + 3'd1;
            end
          end
          orld_pkg::PH_LITERAL: begin
            seq_n[0] = in_byte;
            gl       = GW'(1);
            rem_next = rem_dec;
            if (rem_dec == 9'd0) begin
              fin        = 1'b1;
              phase_next = orld_pkg::PH_OPCODE;
            end
          end
          orld_pkg::PH_STREAM: begin
            if (op == orld_pkg::OP_STR1 || op == orld_pkg::OP_STR2 ||
                op == orld_pkg::OP_STR3) begin
              seq_n[0] = prm_w[1];
              seq_n[1] = prm_w[2];
              seq_n[2] = prm_w[3];
              if (op == orld_pkg::OP_STR1) begin
                seq_n[1]      = in_byte;
                seq_last_next = 2'd1;
              end else if (op == orld_pkg::OP_STR2) begin
                seq_n[2]      = in_byte;
                seq_last_next = 2'd2;
              end else begin
                seq_n[3]      = in_byte;
                seq_last_next = 2'd3;
              end
              gl       = GW'(seq_last_next) + GW'(1);
              rem_next = rem_dec;
              if (rem_dec == 9'd0) begin
                fin        = 1'b1;
                phase_next = orld_pkg::PH_OPCODE;
              end
            end else begin
              fin        = 1'b1;
              phase_next = orld_pkg::PH_OPCODE;
            end
          end
          default: begin
            phase_next = orld_pkg::PH_OPCODE;
          end
        endcase
      end
    end
  end

  // saturating output count after this request's bytes
  assign cnt_sum = {1'b0, count} + {{(25-GW){1'b0}}, gen_left};
  assign cnt_new = cnt_sum[24] ? orld_pkg::COUNT_MAX : cnt_sum[23:0];

  // decoder state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      stopped  <= orld_pkg::ST_RUN;
      src_end  <= 1'b0;
      count    <= '0;
      op       <= '0;
      phase    <= orld_pkg::PH_OPCODE;
      rem      <= '0;
      fin_pend <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        prm[i] <= '0;
      end
    end else if (cmd.decode) begin
      stopped  <= stopped_next;
      src_end  <= src_end_next;
      count    <= count_next;
      op       <= op_next;
      phase    <= phase_next;
      rem      <= rem_next;
      fin_pend <= fin;
      for (int i = 0; i < 4; i++) begin
        prm[i] <= prm_w[i];
      end
    end else if (cmd.settle) begin
      count <= cnt_new;
      if (fin_pend && stopped == orld_pkg::ST_RUN) begin
        if (src_end) begin
          stopped <= orld_pkg::ST_SRC;
        end else if (cnt_new >= limit) begin
          stopped <= orld_pkg::ST_LIMIT;
        end
      end
    end
  end

  // current generator byte
  always_comb begin
    case (kind)
      orld_pkg::GK_SEQ:   gen_byte = seq[seq_pos];
      orld_pkg::GK_ARITH: gen_byte = val[7:0];
      orld_pkg::GK_ACC:   gen_byte = seq_pos[0] ? val[15:8] : val[7:0];
      orld_pkg::GK_COPY:  gen_byte = rd_data;
      default:            gen_byte = val[7:0];
    endcase
  end

  // generator registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_left <= '0;
      kind     <= orld_pkg::GK_SEQ;
      seq_pos  <= '0;
      hist_wr  <= '0;
    end else if (cmd.decode) begin
      gen_left <= gl;
      kind     <= kind_next;
      seq_pos  <= '0;
    end else if (cmd.emit) begin
      gen_left <= gen_left - GW'(1);
      hist_wr  <= hist_wr + AW'(1);
      case (kind)
        orld_pkg::GK_SEQ:  seq_pos <= (seq_pos == seq_last) ? 2'd0 : seq_pos + 2'd1;
        orld_pkg::GK_ACC:  seq_pos <= {1'b0, ~seq_pos[0]};
        default:           seq_pos <= seq_pos;
      endcase
    end
  end

  // generator payload
  always_ff @(posedge clk) begin
    if (cmd.decode) begin
      seq_last <= seq_last_next;
      stepv    <= stepv_next;
      ref_dist <= ref_dist_next;
      val      <= val_next;
      for (int i = 0; i < 4; i++) begin
        seq[i] <= seq_n[i];
      end
    end else if (cmd.emit) begin
      if (kind == orld_pkg::GK_ARITH) begin
        val <= {val[15:8], val[7:0] + stepv[7:0]};
      end else if (kind == orld_pkg::GK_ACC && seq_pos[0]) begin
        val <= val + stepv;
      end
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      hist[hist_wr] <= gen_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data <= hist[hist_wr - ref_dist];
    end
  end

  // result packing
  always_ff @(posedge clk) begin
    if (rst) begin
      pack_cnt <= '0;
      for (int i = 0; i < RB; i++) begin
        pack[i] <= '0;
      end
    end else if (cmd.flush) begin
      pack_cnt <= '0;
      for (int i = 0; i < RB; i++) begin
        pack[i] <= '0;
      end
    end else if (cmd.emit) begin
      pack[pack_cnt[orld_pkg::PACK_IW-1:0]] <= gen_byte;
      pack_cnt <= pack_cnt + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush) begin
      for (int i = 0; i < 8; i++) begin
        out_data_low[8*i +: 8]  <= pack[i];
        out_data_high[8*i +: 8] <= pack[i + 8];
      end
      out_byte_count <= 5'(pack_cnt);
      out_status     <= stopped;
      out_last       <= (gen_left == '0);
    end
  end

  assign sts.gen_done  = (gen_left == '0);
  assign sts.pack_full = (pack_cnt == orld_pkg::PACK_CW'(RB));
  assign sts.is_copy   = (kind == orld_pkg::GK_COPY);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

// ===== src/opcode_rle_lz_byte_decompressor_core.sv =====
// ----------------------------------------------------------------------------
// opcode_rle_lz_byte_decompressor_core: opcode-driven byte decompressor
// Sequence: each accepted request is decoded and settled, then its output bytes
//   are generated (each back-reference byte after its history read) and packed
//   into results of 16 bytes, each flushed once the result register is free.
// A new request is accepted only after the last one has flushed its final result.
// Reset: synchronous; control state cleared, output_limit set to 0xFFFFFF,
//   history contents undefined until written.
// ----------------------------------------------------------------------------
module opcode_rle_lz_byte_decompressor_core (
  input  logic                         clk,
  input  logic                         rst,
  orld_in_if.sink                      compressed,
  orld_out_if.source                   result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [orld_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  orld_pkg::cmd_t cmd;
  orld_pkg::sts_t sts;
  logic [23:0]    output_limit;

  // configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= orld_pkg::COUNT_MAX;
    end else if (psel && penable && pwrite && paddr == orld_pkg::REG_OUTPUT_LIMIT) begin
      output_limit <= pwdata[23:0];
    end
  end

  assign prdata = (paddr == orld_pkg::REG_OUTPUT_LIMIT) ? {8'h00, output_limit} : 32'h0;

  orld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (compressed.valid),
    .in_ready (compressed.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  orld_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_byte_d      (compressed.source_byte),
    .in_last_d      (compressed.last_of_call),
    .in_first_d     (compressed.first_of_call),
    .limit          (output_limit),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_data_low   (result.data_low),
    .out_data_high  (result.data_high),
    .out_byte_count (result.byte_count),
    .out_status     (result.status),
    .out_last       (result.last)
  );

  // one request in flight at a time
  a_single_request: assert property (@(posedge clk) disable iff (rst)
    (compressed.valid && compressed.ready) |=> !compressed.ready)
    else $error("request accepted while previous one in progress");

  // only the final result of a request may be partly filled
  a_full_nonfinal: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.last) |-> result.byte_count == 5'd16)
    else $error("non-final result not full");

  // result never exceeds its byte capacity
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.byte_count <= 5'd16)
    else $error("result byte count out of range");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for opcode_rle_lz_byte_decompressor_core
// Feeds compressed byte streams: a directed pass over every opcode, then
// random opcode sequences with random content under several output limits.
// A scoreboard predicts every result and checks the results in order.
// ----------------------------------------------------------------------------
module tb;
  import orld_pkg::*;

  // predicted result and the decompressor state model
  class decomp_scoreboard;
    typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic [4:0]  cnt;
      logic [1:0]  st;
      logic        lst;
    } chunk_t;

    logic [7:0]  hist [WINDOW_DEPTH];
    int          fill;          // history entries ever written, saturating
    logic [11:0] wr_idx;
    logic [23:0] out_count;
    logic [23:0] limit;
    logic [7:0]  opcode;
    logic [7:0]  prm [4];
    logic [2:0]  phase;
    int          remaining;
    logic [1:0]  stop_code;
    bit          src_end;
    logic [7:0]  step_bytes [$];
    chunk_t      pending [$];
    int          errors;
    int          checked;
    int          consumed;

    function new();
      fill = 0;
      wr_idx = '0;
      out_count = '0;
      limit = COUNT_MAX;
      opcode = '0;
      foreach (prm[i]) prm[i] = '0;
      phase = PH_OPCODE;
      remaining = 0;
      stop_code = ST_RUN;
      src_end = 0;
      errors = 0;
      checked = 0;
      consumed = 0;
    endfunction

    function void emit(logic [7:0] b);
      hist[wr_idx] = b;
      wr_idx++;
      if (fill < WINDOW_DEPTH) fill++;
      if (out_count != COUNT_MAX) out_count++;
      step_bytes.push_back(b);
    endfunction

    // byte-ordered copy: overlapping copies repeat
    function void copy_prior(int dist_back, int n);
      logic [11:0] at;
      for (int i = 0; i < n; i++) begin
        at = wr_idx - 12'(dist_back);
        emit(hist[at]);
      end
    endfunction

    function void close_op();
      phase = PH_OPCODE;
      if (stop_code != ST_RUN) return;
      if (src_end) stop_code = ST_SRC;
      else if (out_count >= limit) stop_code = ST_LIMIT;
    endfunction

    function int params_needed(logic [7:0] op);
      if (op == OP_FILL_NIB || op == OP_REFNIB) return 1;
      if (op == OP_PAT2 || op == OP_STR2 || op == OP_STEP) return 3;
      if (op == OP_PAT3 || op == OP_STR3 || op == OP_ACC16) return 4;
      return 2;
    endfunction

    function void run_op();
      int          n;
      logic [7:0]  v;
      logic [15:0] acc;
      logic [15:0] d;
      case (opcode)
        OP_FILL_NIB: begin
          n = prm[0][3:0] + 3;
          for (int i = 0; i < n; i++) emit({4'h0, prm[0][7:4]});
        end
        OP_FILL: begin
          n = prm[0] + 4;
          for (int i = 0; i < n; i++) emit(prm[1]);
        end
        OP_NIB_PAIR: begin
          n = prm[0] + 2;
          for (int i = 0; i < n; i++) begin
            emit({4'h0, prm[1][3:0]});
            emit({4'h0, prm[1][7:4]});
          end
        end
        OP_PAT2: begin
          n = prm[0] + 2;
          for (int i = 0; i < n; i++) begin
            emit(prm[1]);
            emit(prm[2]);
          end
        end
        OP_PAT3: begin
          n = prm[0] + 2;
          for (int i = 0; i < n; i++) begin
            emit(prm[1]);
            emit(prm[2]);
            emit(prm[3]);
          end
        end
        OP_STR1, OP_STR2, OP_STR3: begin
          remaining = prm[0] + ((opcode == OP_STR1) ? 4 : (opcode == OP_STR2) ? 3 : 2);
          phase = PH_STREAM;
          return;
        end
        OP_INC, OP_DEC: begin
          v = prm[1];
          n = prm[0] + 4;
          for (int i = 0; i < n; i++) begin
            emit(v);
            v = (opcode == OP_INC) ? v + 8'd1 : v - 8'd1;
          end
        end
        OP_STEP: begin
          v = prm[1];
          n = prm[0] + 5;
          for (int i = 0; i < n; i++) begin
            emit(v);
            v = v + prm[2];
          end
        end
        OP_ACC16: begin
          acc = {prm[2], prm[1]};
          d = {{8{prm[3][7]}}, prm[3]};
          n = prm[0] + 3;
          for (int i = 0; i < n; i++) begin
            emit(acc[7:0]);
            emit(acc[15:8]);
            acc = acc + d;
          end
        end
        OP_REF12: copy_prior({prm[1][3:0], prm[0]} + 1, prm[1][7:4] + 4);
        OP_REF8:  copy_prior(prm[0] + 1, prm[1] + 20);
        OP_REFNIB: copy_prior(prm[0][7:4] * 8 + 8, prm[0][3:0] + 3);
        default: ;
      endcase
      close_op();
    endfunction

    function void stream_in(logic [7:0] s);
      case (opcode)
        OP_STR1: emit(prm[1]);
        OP_STR2: begin
          emit(prm[1]);
          emit(prm[2]);
        end
        OP_STR3: begin
          emit(prm[1]);
          emit(prm[2]);
          emit(prm[3]);
        end
        default: begin
          close_op();
          return;
        end
      endcase
      emit(s);
      if (remaining > 0) remaining--;
      if (remaining == 0) close_op();
    endfunction

    function void decode(logic [7:0] b);
      if (phase == PH_OPCODE) begin
        opcode = b;
        if (b <= OP_LIT_MAX) begin
          remaining = b + 1;
          phase = PH_LITERAL;
        end else if (b == OP_END) begin
          stop_code = ST_END;
        end else begin
          phase = 3'd1;
        end
      end else if (phase <= 3'd4) begin
        prm[phase - 3'd1] = b;
        if (phase >= params_needed(opcode)) run_op();
        else phase++;
      end else if (phase == PH_LITERAL) begin
        emit(b);
        if (remaining > 0) remaining--;
        if (remaining == 0) close_op();
      end else if (phase == PH_STREAM) begin
        stream_in(b);
      end else begin
        phase = PH_OPCODE;
      end
    endfunction

    // accepted request: predict its results, return 1 if the byte was used
    function bit note_request(logic [7:0] b, logic lst, logic fst);
      int     nres;
      int     cnt;
      bit     used;
      chunk_t c;
      step_bytes.delete();
      used = 0;
      if (fst) begin
        stop_code = ST_RUN;
        out_count = '0;
        src_end = 0;
      end
      if (stop_code == ST_RUN) begin
        if (phase == PH_OPCODE && out_count >= limit) begin
          stop_code = ST_LIMIT;
        end else begin
          if (lst) src_end = 1;
          decode(b);
          used = 1;
        end
      end
      nres = (step_bytes.size() + RESULT_BYTES - 1) / RESULT_BYTES;
      if (nres == 0) nres = 1;
      for (int k = 0; k < nres; k++) begin
        c.lo = '0;
        c.hi = '0;
        cnt = step_bytes.size() - k * RESULT_BYTES;
        if (cnt < 0) cnt = 0;
        if (cnt > RESULT_BYTES) cnt = RESULT_BYTES;
        for (int j = 0; j < cnt; j++) begin
          if (j < 8) c.lo[8*j +: 8] = step_bytes[k*RESULT_BYTES + j];
          else c.hi[8*(j-8) +: 8] = step_bytes[k*RESULT_BYTES + j];
        end
        c.cnt = 5'(cnt);
        c.st = stop_code;
        c.lst = (k == nres - 1);
        pending.push_back(c);
      end
      if (used) consumed++;
      return used;
    endfunction

    function void check_result(logic [63:0] lo, logic [63:0] hi, logic [4:0] cnt,
                               logic [1:0] st, logic lst);
      chunk_t c;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result lo=%h cnt=%0d", $time, lo, cnt);
        errors++;
        return;
      end
      c = pending.pop_front();
      if (lo !== c.lo) begin
        $display("%0t: data_low expected %h actual %h", $time, c.lo, lo);
        errors++;
      end
      if (hi !== c.hi) begin
        $display("%0t: data_high expected %h actual %h", $time, c.hi, hi);
        errors++;
      end
      if (cnt !== c.cnt) begin
        $display("%0t: byte_count expected %0d actual %0d", $time, c.cnt, cnt);
        errors++;
      end
      if (st !== c.st) begin
        $display("%0t: status expected %0d actual %0d", $time, c.st, st);
        errors++;
      end
      if (lst !== c.lst) begin
        $display("%0t: last expected %0d actual %0d", $time, c.lst, lst);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          cyc;

  orld_in_if  cin();
  orld_out_if cout();

  decomp_scoreboard sb = new();

  opcode_rle_lz_byte_decompressor_core dut (
    .clk        (clk),
    .rst        (rst),
    .compressed (cin),
    .result     (cout),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // result side: random stalls, one long hold-off, one stretch always ready
  initial begin
    cout.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (cyc >= 400 && cyc < 700) cout.ready <= 1'b0;
      else if (cyc >= 1500 && cyc < 4000) cout.ready <= 1'b1;
      else cout.ready <= ($urandom_range(0, 99) >= 13);
      @(posedge clk);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && cout.valid && cout.ready)
      sb.check_result(cout.data_low, cout.data_high, cout.byte_count, cout.status,
                      cout.last);
  end

  function automatic logic [7:0] run_len();
    return ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, 6));
  endfunction

  // opcode choice; back-references only once enough history exists
  function automatic logic [7:0] pick_opcode();
    int         r;
    logic [7:0] op;
    r = $urandom_range(0, 99);
    if (r < 35)
      op = ($urandom_range(0, 40) == 0) ? OP_LIT_MAX : 8'($urandom_range(0, 12));
    else if (r < 96) op = OP_FILL_NIB + 8'($urandom_range(0, 14));
    else if (r < 98) op = OP_END;
    else op = 8'($urandom);
    if (op >= OP_REF12 && op != OP_END && sb.fill < 8) op = OP_FILL;
    return op;
  endfunction

  // parameter choice; distances never reach past written history
  function automatic logic [7:0] pick_param();
    int k;
    int hi_max;
    k = sb.phase - 1;
    case (sb.opcode)
      OP_REF12: begin
        if (k == 0) return 8'($urandom_range(0, (sb.fill > 256) ? 255 : sb.fill - 1));
        hi_max = (sb.fill - 1 - sb.prm[0]) >> 8;
        if (hi_max > 15) hi_max = 15;
        return {4'($urandom), 4'($urandom_range(0, hi_max))};
      end
      OP_REF8: begin
        if (k == 0) return 8'($urandom_range(0, (sb.fill > 256) ? 255 : sb.fill - 1));
        return run_len();
      end
      OP_REFNIB: begin
        hi_max = (sb.fill - 8) / 8;
        if (hi_max > 15) hi_max = 15;
        return {4'($urandom_range(0, hi_max)), 4'($urandom)};
      end
      default: return (k == 0) ? run_len() : 8'($urandom);
    endcase
  endfunction

  // one request; valid stays high back to back unless the sender idles
  task automatic send_req(logic [7:0] b, logic lst, logic fst, output bit used);
    if (!(cyc >= 1500 && cyc < 4000) && $urandom_range(0, 99) < 13) begin
      cin.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cin.valid <= 1'b1;
    cin.source_byte <= b;
    cin.last_of_call <= lst;
    cin.first_of_call <= fst;
    @(posedge clk);
    while (!cin.ready) @(posedge clk);
    used = sb.note_request(b, lst, fst);
  endtask

  task automatic feed(logic [7:0] forced, bit use_forced, bit force_first,
                      output bit used);
    logic [7:0] b;
    logic       f;
    logic       l;
    if (sb.stop_code != ST_RUN) f = ($urandom_range(0, 99) < 85);
    else f = ($urandom_range(0, 79) == 0);
    if (force_first) f = 1'b1;
    l = ($urandom_range(0, 59) == 0);
    if (use_forced) b = forced;
    else if (sb.phase == PH_OPCODE) b = pick_opcode();
    else if (sb.phase <= 3'd4) b = pick_param();
    else b = 8'($urandom);
    send_req(b, l, f, used);
  endtask

  // called in the step of the last accept: lower valid and let results drain
  task automatic drain();
    cin.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(logic [23:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_OUTPUT_LIMIT;
    pwdata <= {8'h00, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.limit = val;
  endtask

  initial begin
    #40000000;
    $display("timeout");
    $display("FAIL opcode_rle_lz_byte_decompressor_core");
    $finish;
  end

  initial begin
    logic [7:0]  dir_ops [$];
    logic [23:0] limits [$];
    bit          used;
    int          tries;
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cin.valid <= 1'b0;
    cin.source_byte <= '0;
    cin.last_of_call <= 1'b0;
    cin.first_of_call <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every opcode once, end marker last
    dir_ops.push_back(8'h00);
    for (int op = OP_FILL_NIB; op <= OP_END; op++) dir_ops.push_back(8'(op));
    foreach (dir_ops[i]) begin
      feed(dir_ops[i], 1, i == 0, used);
      while (sb.phase != PH_OPCODE && sb.stop_code == ST_RUN) feed(8'h00, 0, 0, used);
    end
    feed(OP_LIT_MAX - 8'd1, 1, 1, used);
    feed(8'h5A, 0, 0, used);

    // random phases, each under its own output limit
    limits.push_back(COUNT_MAX);
    limits.push_back(24'd0);
    limits.push_back(24'd37);
    limits.push_back(24'($urandom_range(60, 500)));
    limits.push_back(24'd1);
    limits.push_back(COUNT_MAX);
    foreach (limits[i]) begin
      drain();
      cfg_write(limits[i]);
      tries = 0;
      while (tries < 50) begin
        feed(8'h00, 0, 0, used);
        tries++;
      end
    end

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d consumed bytes, %0d results checked, %0d output limits.",
             sb.consumed, sb.checked, limits.size() + 1);
    if (sb.pending.size() != 0) begin
      $display("%0d expected results never arrived", sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("PASS opcode_rle_lz_byte_decompressor_core");
    end else begin
      $display("FAIL opcode_rle_lz_byte_decompressor_core");
    end
    $finish;
  end
endmodule
